[hdl/bdq_pkg.sv]
`default_nettype none

package bdq_pkg;

   localparam int unsigned DEPTH_DEFAULT = 1024;
   localparam int unsigned CAP_WIDTH     = 11;
   localparam int unsigned VALUE_WIDTH   = 32;
   localparam int unsigned KIND_WIDTH    = 3;

   localparam logic [CAP_WIDTH-1:0]          CAP_RESET   = CAP_WIDTH'(1024);
   localparam logic signed [VALUE_WIDTH-1:0] EMPTY_VALUE = -VALUE_WIDTH'(1);

   localparam logic [KIND_WIDTH-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_QUERY      = 3'd4;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]          kind;
      logic signed [VALUE_WIDTH-1:0]  value;
   } req_type;

   typedef struct packed {
      logic                           ok;
      logic signed [VALUE_WIDTH-1:0]  front_value;
      logic signed [VALUE_WIDTH-1:0]  rear_value;
      logic                           empty_res;
      logic                           full_res;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/bounded_deque_core.sv]
// Bounded double-ended queue of 32-bit signed entries kept in a ring buffer.
// Request channel (req_valid, req_stall, req_item): each item carries an
// operation kind (push front, push back, pop front, pop back, query) and a
// value used by pushes. Response channel (rsp_valid, rsp_stall, rsp_item):
// exactly one item per request with the success flag, the front and rear
// entries after the operation (-1 when empty) and the empty and full flags.
// The capacity register is written through csr_we and csr_wdata; the user
// must write it only while the block is idle, which the block itself does not
// enforce. Zero acts as one and values above DEPTH act as DEPTH. The entry
// memory is written or read in the cycle of acceptance, and its registered
// read data forms the result in the next cycle, when the response register
// is loaded; no new item is accepted until then.
// Reset empties the deque, sets the head to zero and capacity to 1024; the
// memory is not cleared, since no entry is read before it is written.
// While the receiver stalls, the response register holds its item and the
// request channel stalls, so no result is lost or overwritten.
`default_nettype none

module bounded_deque_core #(
   parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire bdq_pkg::req_type                  req_item,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output bdq_pkg::rsp_type                       rsp_item,
   input  wire logic                              csr_we,
   input  wire logic [bdq_pkg::CAP_WIDTH-1:0]     csr_wdata
);
   import bdq_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned LW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;
   localparam int unsigned SW = AW + 2;
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
   localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

   function automatic logic [AW-1:0] wrap_index(input logic [SW-1:0] s);
      logic [SW-1:0] t;
      t = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
      return t[AW-1:0];
   endfunction

   logic signed [VALUE_WIDTH-1:0] store_mem [DEPTH];

   logic                          busy_ff;
   logic                          rsp_valid_ff;
   logic [AW-1:0]                 head_ff, head_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CAP_WIDTH-1:0]          cap_ff;
   logic signed [VALUE_WIDTH-1:0] front_ff, front_in;
   logic signed [VALUE_WIDTH-1:0] rear_ff, rear_in;
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;
   rsp_type                       rsp_ff;

   logic                          ok_ff, ok_in;
   logic                          empty_ff, full_ff;
   logic                          sel_front_ff, sel_front_in;
   logic                          sel_rear_ff, sel_rear_in;
   logic signed [VALUE_WIDTH-1:0] front_pend_ff, front_pend_in;
   logic signed [VALUE_WIDTH-1:0] rear_pend_ff, rear_pend_in;

   logic                          accept;
   logic [LW-1:0]                 eff_cap;
   logic                          full_now, empty_now;
   logic [AW-1:0]                 head_dec, head_inc, back_addr, last_addr;
   logic                          mem_we;
   logic [AW-1:0]                 wr_addr, rd_addr;

   assign accept    = req_valid && !req_stall;
   assign req_stall = busy_ff || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = LW'(1);
      end else if (LW'(cap_ff) > DEPTH_L) begin
         eff_cap = DEPTH_L;
      end else begin
         eff_cap = LW'(cap_ff);
      end
   end

   assign full_now  = LW'(count_ff) >= eff_cap;
   assign empty_now = (count_ff == '0);
   assign head_dec  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign head_inc  = wrap_index(SW'(head_ff) + SW'(1));
   assign back_addr = wrap_index(SW'(head_ff) + SW'(count_ff));
   assign last_addr = wrap_index(SW'(head_ff) + SW'(count_ff) - SW'(2));

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      ok_in         = 1'b0;
      mem_we        = 1'b0;
      wr_addr       = back_addr;
      rd_addr       = head_inc;
      sel_front_in  = 1'b0;
      sel_rear_in   = 1'b0;
      front_pend_in = front_ff;
      rear_pend_in  = rear_ff;
      unique case (req_item.kind)
         KIND_PUSH_FRONT: begin
            if (!full_now) begin
               head_in       = head_dec;
               count_in      = count_ff + CW'(1);
               ok_in         = 1'b1;
               mem_we        = 1'b1;
               wr_addr       = head_dec;
               front_pend_in = req_item.value;
               rear_pend_in  = empty_now ? req_item.value : rear_ff;
            end
         end
         KIND_PUSH_BACK: begin
            if (!full_now) begin
               count_in      = count_ff + CW'(1);
               ok_in         = 1'b1;
               mem_we        = 1'b1;
               wr_addr       = back_addr;
               rear_pend_in  = req_item.value;
               front_pend_in = empty_now ? req_item.value : front_ff;
            end
         end
         KIND_POP_FRONT: begin
            if (!empty_now) begin
               head_in      = head_inc;
               count_in     = count_ff - CW'(1);
               ok_in        = 1'b1;
               rd_addr      = head_inc;
               sel_front_in = 1'b1;
            end
         end
         KIND_POP_BACK: begin
            if (!empty_now) begin
               count_in    = count_ff - CW'(1);
               ok_in       = 1'b1;
               rd_addr     = last_addr;
               sel_rear_in = 1'b1;
            end
         end
         KIND_QUERY: begin
            ok_in = 1'b1;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   assign front_in = sel_front_ff ? rd_data_ff : front_pend_ff;
   assign rear_in  = sel_rear_ff ? rd_data_ff : rear_pend_ff;

   always_ff @(posedge clock) begin
      if (accept && mem_we) begin
         store_mem[wr_addr] <= req_item.value;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         if (accept) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
         busy_ff <= accept;
         if (busy_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff         <= ok_in;
         empty_ff      <= (count_in == '0);
         full_ff       <= LW'(count_in) >= eff_cap;
         sel_front_ff  <= sel_front_in;
         sel_rear_ff   <= sel_rear_in;
         front_pend_ff <= front_pend_in;
         rear_pend_ff  <= rear_pend_in;
      end
      if (busy_ff) begin
         front_ff             <= front_in;
         rear_ff              <= rear_in;
         rsp_ff.ok            <= ok_ff;
         rsp_ff.front_value   <= empty_ff ? EMPTY_VALUE : front_in;
         rsp_ff.rear_value    <= empty_ff ? EMPTY_VALUE : rear_in;
         rsp_ff.empty_res     <= empty_ff;
         rsp_ff.full_res      <= full_ff;
      end
   end

   // The entry count never exceeds the storage depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds storage depth");

   // An accepted item is followed by the result cycle with the response register free.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && !rsp_valid_ff)
      else $error("result cycle missing or response register occupied");

   // The reported empty flag matches the count once the result is loaded.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> rsp_valid_ff && (rsp_ff.empty_res == (count_ff == '0)))
      else $error("empty flag disagrees with entry count");

   // A successful push grows the count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      accept && ok_in && mem_we |=> count_ff == $past(count_ff) + CW'(1))
      else $error("push did not increment entry count");

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import bdq_pkg::*;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam logic [KIND_WIDTH-1:0] KIND_UNUSED_LOW = KIND_QUERY + 1'b1;
   localparam logic [KIND_WIDTH-1:0] KIND_UNUSED_HIGH = '1;

   // Shadow copy of the ring buffer; every accepted request queues the status item it
   // should produce, and every response item is checked against the oldest one.
   class deque_mirror;
      localparam int unsigned RING = DEPTH_DEFAULT;
      logic signed [VALUE_WIDTH-1:0] entries [RING];
      int unsigned head;
      logic [CAP_WIDTH-1:0] count;
      logic [CAP_WIDTH-1:0] capacity;
      rsp_type awaited[$];
      int unsigned mismatches;

      function new();
         head = 0;
         count = '0;
         capacity = CAP_RESET;
         mismatches = 0;
      endfunction

      function int unsigned usable_capacity();
         if (capacity == 0) begin
            return 1;
         end
         if (capacity > RING) begin
            return RING;
         end
         return capacity;
      endfunction

      function void apply_request(req_type r);
         rsp_type res;
         int unsigned cap_now;
         logic done;
         cap_now = usable_capacity();
         done = 1'b0;
         case (r.kind)
            KIND_PUSH_FRONT: begin
               if (count < cap_now) begin
                  head = (head + RING - 1) % RING;
                  entries[head] = r.value;
                  count++;
                  done = 1'b1;
               end
            end
            KIND_PUSH_BACK: begin
               if (count < cap_now) begin
                  entries[(head + count) % RING] = r.value;
                  count++;
                  done = 1'b1;
               end
            end
            KIND_POP_FRONT: begin
               if (count != 0) begin
                  head = (head + 1) % RING;
                  count--;
                  done = 1'b1;
               end
            end
            KIND_POP_BACK: begin
               if (count != 0) begin
                  count--;
                  done = 1'b1;
               end
            end
            KIND_QUERY: begin
               done = 1'b1;
            end
            default: begin
               done = 1'b0;
            end
         endcase
         res.ok = done;
         if (count == 0) begin
            res.front_value = EMPTY_VALUE;
            res.rear_value = EMPTY_VALUE;
         end else begin
            res.front_value = entries[head];
            res.rear_value = entries[(head + count - 1) % RING];
         end
         res.empty_res = (count == 0);
         res.full_res = (count >= cap_now);
         awaited.push_back(res);
      endfunction

      function void compare_field(string field, logic signed [63:0] want,
                                  logic signed [63:0] seen);
         if (want !== seen) begin
            $error("%s: expected %0d, got %0d", field, want, seen);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            $error("response item arrived with no request outstanding");
            mismatches++;
         end else begin
            want = awaited.pop_front();
            compare_field("ok", want.ok, got.ok);
            compare_field("front_value", want.front_value, got.front_value);
            compare_field("rear_value", want.rear_value, got.rear_value);
            compare_field("empty_res", want.empty_res, got.empty_res);
            compare_field("full_res", want.full_res, got.full_res);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_item;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_item;
   logic csr_we;
   logic [CAP_WIDTH-1:0] csr_wdata;

   deque_mirror mirror = new();
   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   int unsigned sent_total;
   int unsigned quiet_cycles;

   bounded_deque_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         mirror.check_response(rsp_item);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic update_pacing();
      if (sent_total < 700) begin
         sender_idle_pct = 12;
         receiver_stall_pct = 71;
      end else if (sent_total < 1400) begin
         sender_idle_pct = 71;
         receiver_stall_pct = 12;
      end else begin
         sender_idle_pct = 0;
         receiver_stall_pct = 0;
      end
   endtask

   task automatic send_request(input logic [KIND_WIDTH-1:0] kind,
                               input logic signed [VALUE_WIDTH-1:0] value);
      req_type item;
      item.kind = kind;
      item.value = value;
      update_pacing();
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mirror.apply_request(item);
      sent_total++;
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (mirror.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_WIDTH-1:0] cap);
      drain_responses();
      csr_we <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we <= 1'b0;
      mirror.capacity = cap;
   endtask

   function automatic logic [KIND_WIDTH-1:0] random_kind(int unsigned push_pct,
                                                          int unsigned pop_pct);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < push_pct) begin
         return $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
      end else if (roll < push_pct + pop_pct) begin
         return $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
      end else if ($urandom_range(3) != 0) begin
         return KIND_QUERY;
      end
      return KIND_WIDTH'($urandom_range(KIND_UNUSED_HIGH, KIND_UNUSED_LOW));
   endfunction

   function automatic logic signed [VALUE_WIDTH-1:0] random_value();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return EMPTY_VALUE;
         default: return $urandom();
      endcase
   endfunction

   task automatic run_mix(input logic [CAP_WIDTH-1:0] cap, input int unsigned items,
                          input int unsigned push_pct, input int unsigned pop_pct);
      int unsigned n;
      set_capacity(cap);
      for (n = 0; n < items; n++) begin
         if ($urandom_range(63) == 0) begin
            drain_responses();
         end
         send_request(random_kind(push_pct, pop_pct), random_value());
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_item <= '0;
      rsp_stall <= 1'b0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      quiet_cycles <= 0;
      sent_total = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_request(KIND_QUERY, '0);
      send_request(KIND_POP_FRONT, '0);
      send_request(KIND_POP_BACK, '1);
      send_request(KIND_UNUSED_LOW, '0);
      send_request(KIND_PUSH_FRONT, 32'h8000_0000);
      send_request(KIND_PUSH_BACK, 32'h7fff_ffff);
      send_request(KIND_PUSH_FRONT, EMPTY_VALUE);
      send_request(KIND_PUSH_BACK, '0);
      send_request(KIND_QUERY, 32'h1234_5678);
      send_request(KIND_UNUSED_LOW + 1'b1, '0);
      send_request(KIND_UNUSED_HIGH, '1);
      send_request(KIND_POP_FRONT, '0);
      send_request(KIND_POP_BACK, '0);
      send_request(KIND_POP_FRONT, '0);
      send_request(KIND_POP_BACK, '0);
      send_request(KIND_POP_BACK, '0);

      set_capacity('0);
      send_request(KIND_PUSH_BACK, 32'h5555_5555);
      send_request(KIND_PUSH_FRONT, 32'haaaa_aaaa);
      send_request(KIND_PUSH_BACK, 32'h0f0f_0f0f);
      send_request(KIND_QUERY, '0);
      send_request(KIND_POP_FRONT, '0);
      send_request(KIND_POP_FRONT, '0);

      run_mix(11'd8, 150, 50, 40);
      run_mix(11'd1, 100, 45, 45);
      run_mix('1, 1080, 99, 1);
      run_mix(11'd5, 300, 20, 70);
      run_mix(CAP_RESET, 250, 48, 44);
      drain_responses();

      if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
